FILE: sv/i2cbe_pkg.sv
// Shared types, constants and helper functions for the I2C master bit engine.
// Used by the front end, the queue, the bus engine and the top level.
package i2cbe_pkg;

	localparam int DELAY_BITS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 16;
	localparam int CFG_AW    = 4;

	localparam logic [CFG_AW-1:0] ADDR_LONG_DELAY  = 4'h0;
	localparam logic [CFG_AW-1:0] ADDR_SHORT_DELAY = 4'h4;
	localparam logic [CFG_AW-1:0] ADDR_POLL_LIMIT  = 4'h8;

	localparam logic [15:0] LONG_DELAY_RST  = 16'd16;
	localparam logic [15:0] SHORT_DELAY_RST = 16'd8;
	localparam logic [7:0]  POLL_LIMIT_RST  = 8'd250;

	localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_BITS) - 33'd1;

	typedef enum logic [2:0] {
		ACT_START    = 3'd0,
		ACT_STOP     = 3'd1,
		ACT_WRITE    = 3'd2,
		ACT_WAIT_ACK = 3'd3,
		ACT_READ     = 3'd4
	} act_t;

	typedef struct packed {
		logic       cmd;
		act_t       action;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [15:0] long_delay;
		logic [15:0] short_delay;
		logic [7:0]  poll_limit;
	} cfg_t;

	function automatic logic [DELAY_BITS-1:0] load_delay(input logic [15:0] ticks);
		logic [32:0] d;
		d = {17'd0, ticks};
		if (d == 33'd0) begin
			d = 33'd1;
		end
		if (d > DELAY_MAX) begin
			d = DELAY_MAX;
		end
		return d[DELAY_BITS-1:0];
	endfunction

endpackage

FILE: sv/i2cbe_front.sv
// Front end: unpacks a stream transfer into one tick item and marks whether it
// carries a command that the engine can run. Depends on i2cbe_pkg.
module i2cbe_front (
	input  logic [i2cbe_pkg::S_TDATA_W-1:0] tdata,
	input  logic [i2cbe_pkg::S_TUSER_W-1:0] tuser,
	output i2cbe_pkg::item_t                item
);
	import i2cbe_pkg::*;

	logic [2:0] act_raw;

	assign act_raw = tuser[3:1];

	always_comb begin
		item.cmd      = tuser[0] && (act_raw <= 3'(ACT_READ));
		item.action   = act_t'(act_raw);
		item.tx_byte  = tdata[7:0];
		item.send_ack = tdata[8];
		item.sda_in   = tdata[9];
	end

endmodule

FILE: sv/i2cbe_fifo.sv
// Short queue of tick items between the front end and the bus engine.
// Depends on i2cbe_pkg for the item type and the depth.
module i2cbe_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  i2cbe_pkg::item_t          wr_item,
	input  logic                      pop,
	output i2cbe_pkg::item_t          rd_item,
	output logic                      full,
	output logic                      not_empty,
	output logic [i2cbe_pkg::FIFO_AW:0] level
);
	import i2cbe_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/i2cbe_engine.sv
// Bus engine: runs the I2C phase sequencer one tick item at a time and holds
// the result in an output register. Depends on i2cbe_pkg.
module i2cbe_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  i2cbe_pkg::cfg_t                 cfg,
	input  i2cbe_pkg::item_t                item,
	input  logic                            item_valid,
	output logic                            item_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [i2cbe_pkg::M_TDATA_W-1:0] m_tdata
);
	import i2cbe_pkg::*;

	typedef enum logic [12:0] {
		PH_IDLE    = 13'b0000000000001,
		PH_ST1     = 13'b0000000000010,
		PH_ST2     = 13'b0000000000100,
		PH_SP1     = 13'b0000000001000,
		PH_SP2     = 13'b0000000010000,
		PH_POLL    = 13'b0000000100000,
		PH_WR_HIGH = 13'b0000001000000,
		PH_WR_LOW  = 13'b0000010000000,
		PH_WR_NEXT = 13'b0000100000000,
		PH_RD_HIGH = 13'b0001000000000,
		PH_RD_NEXT = 13'b0010000000000,
		PH_AK_HIGH = 13'b0100000000000,
		PH_AK_LOW  = 13'b1000000000000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [DELAY_BITS-1:0] delay_q, delay_d;
	logic [3:0]            bit_q, bit_d;
	logic [7:0]            shift_q, shift_d;
	logic [7:0]            poll_q, poll_d;
	act_t                  act_q, act_d;
	logic                  ack_q, ack_d;
	logic                  scl_q, scl_d;
	logic                  sda_q, sda_d;
	logic                  drive_q, drive_d;
	logic [7:0]            rx_q, rx_d;
	logic                  done_d, err_d;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic [3:0]            bit_inc;

	assign item_pop = item_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign bit_inc  = bit_q + 4'd1;

	always_comb begin
		phase_d = phase_q;
		delay_d = delay_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		act_d   = act_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		drive_d = drive_q;
		rx_d    = rx_q;
		done_d  = 1'b0;
		err_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.cmd) begin
				act_d = item.action;
				ack_d = item.send_ack;
				bit_d = 4'd0;
				poll_d = 8'd0;
				unique case (item.action)
					ACT_START: begin
						sda_d = 1'b1;
						scl_d = 1'b1;
						drive_d = 1'b1;
						delay_d = load_delay(cfg.long_delay);
						phase_d = PH_ST1;
					end
					ACT_STOP: begin
						scl_d = 1'b0;
						sda_d = 1'b0;
						drive_d = 1'b1;
						delay_d = load_delay(cfg.long_delay);
						phase_d = PH_SP1;
					end
					ACT_WRITE: begin
						scl_d = 1'b0;
						drive_d = 1'b1;
						sda_d = item.tx_byte[7];
						shift_d = {item.tx_byte[6:0], 1'b0};
						delay_d = load_delay(cfg.long_delay);
						phase_d = PH_WR_HIGH;
					end
					ACT_WAIT_ACK: begin
						drive_d = 1'b0;
						sda_d = 1'b1;
						scl_d = 1'b1;
						delay_d = load_delay(cfg.short_delay);
						phase_d = PH_POLL;
					end
					default: begin
						drive_d = 1'b0;
						scl_d = 1'b0;
						shift_d = 8'd0;
						delay_d = load_delay(cfg.long_delay);
						phase_d = PH_RD_HIGH;
					end
				endcase
			end
		end else if (delay_q > DELAY_BITS'(1)) begin
			delay_d = delay_q - 1'b1;
		end else begin
			unique case (phase_q)
				PH_ST1: begin
					sda_d = 1'b0;
					delay_d = load_delay(cfg.long_delay);
					phase_d = PH_ST2;
				end
				PH_ST2: begin
					scl_d = 1'b0;
					phase_d = PH_IDLE;
					done_d = 1'b1;
				end
				PH_SP1: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					delay_d = load_delay(cfg.long_delay);
					phase_d = PH_SP2;
				end
				PH_SP2: begin
					err_d = (act_q == ACT_WAIT_ACK);
					phase_d = PH_IDLE;
					done_d = 1'b1;
				end
				PH_POLL: begin
					if (!item.sda_in) begin
						drive_d = 1'b1;
						scl_d = 1'b0;
						phase_d = PH_IDLE;
						done_d = 1'b1;
					end else if (poll_q >= cfg.poll_limit) begin
						scl_d = 1'b0;
						sda_d = 1'b0;
						drive_d = 1'b1;
						delay_d = load_delay(cfg.long_delay);
						phase_d = PH_SP1;
					end else begin
						poll_d = poll_q + 8'd1;
						delay_d = '0;
					end
				end
				PH_WR_HIGH: begin
					scl_d = 1'b1;
					delay_d = load_delay(cfg.long_delay);
					phase_d = PH_WR_LOW;
				end
				PH_WR_LOW: begin
					scl_d = 1'b0;
					delay_d = load_delay(cfg.long_delay);
					phase_d = PH_WR_NEXT;
				end
				PH_WR_NEXT: begin
					bit_d = bit_inc;
					if (bit_inc < 4'd8) begin
						sda_d = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						delay_d = load_delay(cfg.long_delay);
						phase_d = PH_WR_HIGH;
					end else begin
						phase_d = PH_IDLE;
						done_d = 1'b1;
					end
				end
				PH_RD_HIGH: begin
					scl_d = 1'b1;
					shift_d = {shift_q[6:0], item.sda_in};
					delay_d = load_delay(cfg.short_delay);
					phase_d = PH_RD_NEXT;
				end
				PH_RD_NEXT: begin
					bit_d = bit_inc;
					scl_d = 1'b0;
					delay_d = load_delay(cfg.long_delay);
					if (bit_inc < 4'd8) begin
						phase_d = PH_RD_HIGH;
					end else begin
						drive_d = 1'b1;
						sda_d = !ack_q;
						phase_d = PH_AK_HIGH;
					end
				end
				PH_AK_HIGH: begin
					scl_d = 1'b1;
					delay_d = load_delay(cfg.long_delay);
					phase_d = PH_AK_LOW;
				end
				PH_AK_LOW: begin
					scl_d = 1'b0;
					rx_d = shift_q;
					phase_d = PH_IDLE;
					done_d = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			poll_q <= '0;
			act_q <= ACT_START;
			ack_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			drive_q <= 1'b1;
			rx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				phase_q <= phase_d;
				delay_q <= delay_d;
				bit_q <= bit_d;
				shift_q <= shift_d;
				poll_q <= poll_d;
				act_q <= act_d;
				ack_q <= ack_d;
				scl_q <= scl_d;
				sda_q <= sda_d;
				drive_q <= drive_d;
				rx_q <= rx_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			m_tdata_q <= {2'b00, err_d, rx_d, done_d, (phase_d != PH_IDLE),
				drive_d, sda_d, scl_d};
		end
	end

endmodule

FILE: sv/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: stream ports, APB register file,
// front end, item queue and bus engine. Depends on i2cbe_pkg and the submodules.
//
// Each input transfer is one bus timing tick: s_tdata carries tx_byte, send_ack
// and the sampled SDA level, s_tuser carries cmd_valid and action. Every input
// transfer produces exactly one output transfer with the pin levels, busy and
// done flags, the last received byte and the acknowledge error flag as they
// stand after that tick. A command is taken only on a tick where the engine is
// idle; commands offered while busy and undefined actions are ignored.
// Each accepted input transfer is registered in the queue, and its result is
// registered in the output register. Throughput is one tick per cycle while the
// output receiver takes transfers; a stall holds the queue.
// A four-entry queue sits between the front end and the engine; when the output
// receiver stalls, the output register holds its transfer, the queue fills and
// s_tready falls once it is full. Reset empties the queue and output register,
// puts the engine idle with SCL and SDA driven high, and loads the delay
// registers with 16 and 8 ticks and the poll limit with 250.
// Registers: 0x0 long delay, 0x4 short delay, 0x8 poll limit.
module i2c_master_bit_engine_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
	input  logic [i2cbe_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] cmd_valid, [3:1] action
	input  logic [i2cbe_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [12:5] rx_byte, [13] ack_error, [15:14] zero
	output logic [i2cbe_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [i2cbe_pkg::CFG_AW-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import i2cbe_pkg::*;

	cfg_t             cfg_q;
	item_t            front_item;
	item_t            queue_item;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;
	logic [FIFO_AW:0] q_level;
	logic             cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_delay  <= LONG_DELAY_RST;
			cfg_q.short_delay <= SHORT_DELAY_RST;
			cfg_q.poll_limit  <= POLL_LIMIT_RST;
		end else if (cfg_wr) begin
			priority if (paddr == ADDR_LONG_DELAY) begin
				cfg_q.long_delay <= pwdata[15:0];
			end else if (paddr == ADDR_SHORT_DELAY) begin
				cfg_q.short_delay <= pwdata[15:0];
			end else if (paddr == ADDR_POLL_LIMIT) begin
				cfg_q.poll_limit <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		priority if (paddr == ADDR_LONG_DELAY) begin
			prdata = {16'd0, cfg_q.long_delay};
		end else if (paddr == ADDR_SHORT_DELAY) begin
			prdata = {16'd0, cfg_q.short_delay};
		end else if (paddr == ADDR_POLL_LIMIT) begin
			prdata = {24'd0, cfg_q.poll_limit};
		end else begin
			prdata = 32'd0;
		end
	end

	i2cbe_front u_front (
		.tdata (s_tdata),
		.tuser (s_tuser),
		.item  (front_item)
	);

	i2cbe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.wr_item   (front_item),
		.pop       (q_pop),
		.rd_item   (queue_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.level     (q_level)
	);

	i2cbe_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (queue_item),
		.item_valid (q_not_empty),
		.item_pop   (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// A completed command always leaves the engine idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[3])
		else $error("done reported while still busy");

	// An acknowledge error is only reported on the completing tick.
	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[4])
		else $error("ack error without done");

	// The queue never holds more items than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue overflow");

	// A pop only happens when the queue holds an item.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_level != '0)
		else $error("pop from empty queue");

endmodule

FILE: sim/tb_i2c_master_bit_engine_top.sv
// Self-checking testbench for the I2C master bit engine top level.
// Drives timing ticks and register writes, predicts every output transfer and
// compares it field by field. Depends on i2cbe_pkg and i2c_master_bit_engine_top.
module tb_i2c_master_bit_engine_top;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cbe_pkg::*;

	localparam int SDA_LOW = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_COIN = 2;
	localparam int SDA_MOSTLY_HIGH = 3;

	typedef enum logic [3:0] {
		BP_IDLE,
		BP_START_HOLD,
		BP_START_LOW,
		BP_STOP_LOW,
		BP_STOP_HIGH,
		BP_ACK_POLL,
		BP_WBIT_SET,
		BP_WBIT_HIGH,
		BP_WBIT_LOW,
		BP_RBIT_LOW,
		BP_RBIT_HIGH,
		BP_MACK_LOW,
		BP_MACK_HIGH
	} bus_phase_t;

	typedef struct packed {
		logic       cmd;
		logic [2:0] act;
		logic [7:0] tx;
		logic       ack;
		logic       sda;
	} tick_t;

	typedef struct packed {
		bus_phase_t            phase;
		logic [DELAY_BITS-1:0] cnt;
		logic [3:0]            bits;
		logic [7:0]            sreg;
		logic [7:0]            polls;
		logic [2:0]            act;
		logic                  ack_sel;
		logic                  scl;
		logic                  sda;
		logic                  drv;
		logic [7:0]            rx;
	} eng_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       err;
	} res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [CFG_AW-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	tick_t ticks_pending[$];
	res_t  levels_due[$];
	eng_t  plan;
	eng_t  live;
	cfg_t  bus_cfg;
	tick_t fed;
	tick_t next_tick;
	res_t  seen;
	res_t  want;
	logic  in_fire;
	logic  calm;
	int    send_gap;
	int    ready_gap;
	int    mism;

	i2c_master_bit_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic eng_t fresh_engine();
		eng_t e;
		e = '0;
		e.phase = BP_IDLE;
		e.scl = 1'b1;
		e.sda = 1'b1;
		e.drv = 1'b1;
		return e;
	endfunction

	function automatic logic [DELAY_BITS-1:0] hold_ticks(input logic [15:0] t);
		return (t == 16'd0) ? DELAY_BITS'(1) : DELAY_BITS'(t);
	endfunction

	function automatic void begin_stop(inout eng_t e, input cfg_t c);
		e.scl = 1'b0;
		e.sda = 1'b0;
		e.drv = 1'b1;
		e.cnt = hold_ticks(c.long_delay);
		e.phase = BP_STOP_LOW;
	endfunction

	function automatic void next_wbit(inout eng_t e, input cfg_t c);
		e.sda = e.sreg[7];
		e.sreg = {e.sreg[6:0], 1'b0};
		e.cnt = hold_ticks(c.long_delay);
		e.phase = BP_WBIT_SET;
	endfunction

	function automatic res_t tick_engine(inout eng_t e, input cfg_t c, input tick_t t);
		res_t r;
		logic done;
		logic err;
		done = 1'b0;
		err = 1'b0;
		if (e.phase == BP_IDLE) begin
			if (t.cmd && t.act <= ACT_READ) begin
				e.act = t.act;
				e.ack_sel = t.ack;
				e.bits = '0;
				e.polls = '0;
				case (t.act)
				ACT_START: begin
					e.sda = 1'b1;
					e.scl = 1'b1;
					e.drv = 1'b1;
					e.cnt = hold_ticks(c.long_delay);
					e.phase = BP_START_HOLD;
				end
				ACT_STOP: begin
					begin_stop(e, c);
				end
				ACT_WRITE: begin
					e.scl = 1'b0;
					e.drv = 1'b1;
					e.sreg = t.tx;
					next_wbit(e, c);
				end
				ACT_WAIT_ACK: begin
					e.drv = 1'b0;
					e.sda = 1'b1;
					e.scl = 1'b1;
					e.cnt = hold_ticks(c.short_delay);
					e.phase = BP_ACK_POLL;
				end
				default: begin
					e.drv = 1'b0;
					e.scl = 1'b0;
					e.sreg = '0;
					e.cnt = hold_ticks(c.long_delay);
					e.phase = BP_RBIT_LOW;
				end
				endcase
			end
		end else if (e.cnt > 1) begin
			e.cnt = e.cnt - 1'b1;
		end else begin
			case (e.phase)
			BP_START_HOLD: begin
				e.sda = 1'b0;
				e.cnt = hold_ticks(c.long_delay);
				e.phase = BP_START_LOW;
			end
			BP_START_LOW: begin
				e.scl = 1'b0;
				e.phase = BP_IDLE;
				done = 1'b1;
			end
			BP_STOP_LOW: begin
				e.scl = 1'b1;
				e.sda = 1'b1;
				e.cnt = hold_ticks(c.long_delay);
				e.phase = BP_STOP_HIGH;
			end
			BP_STOP_HIGH: begin
				err = (e.act == ACT_WAIT_ACK);
				e.phase = BP_IDLE;
				done = 1'b1;
			end
			BP_ACK_POLL: begin
				if (!t.sda) begin
					e.drv = 1'b1;
					e.scl = 1'b0;
					e.phase = BP_IDLE;
					done = 1'b1;
				end else if (e.polls >= c.poll_limit) begin
					begin_stop(e, c);
				end else begin
					e.polls = e.polls + 1'b1;
					e.cnt = '0;
				end
			end
			BP_WBIT_SET: begin
				e.scl = 1'b1;
				e.cnt = hold_ticks(c.long_delay);
				e.phase = BP_WBIT_HIGH;
			end
			BP_WBIT_HIGH: begin
				e.scl = 1'b0;
				e.cnt = hold_ticks(c.long_delay);
				e.phase = BP_WBIT_LOW;
			end
			BP_WBIT_LOW: begin
				e.bits = e.bits + 1'b1;
				if (e.bits < 4'd8) begin
					next_wbit(e, c);
				end else begin
					e.phase = BP_IDLE;
					done = 1'b1;
				end
			end
			BP_RBIT_LOW: begin
				e.scl = 1'b1;
				e.sreg = {e.sreg[6:0], t.sda};
				e.cnt = hold_ticks(c.short_delay);
				e.phase = BP_RBIT_HIGH;
			end
			BP_RBIT_HIGH: begin
				e.bits = e.bits + 1'b1;
				e.scl = 1'b0;
				e.cnt = hold_ticks(c.long_delay);
				if (e.bits < 4'd8) begin
					e.phase = BP_RBIT_LOW;
				end else begin
					e.drv = 1'b1;
					e.sda = ~e.ack_sel;
					e.phase = BP_MACK_LOW;
				end
			end
			BP_MACK_LOW: begin
				e.scl = 1'b1;
				e.cnt = hold_ticks(c.long_delay);
				e.phase = BP_MACK_HIGH;
			end
			BP_MACK_HIGH: begin
				e.scl = 1'b0;
				e.rx = e.sreg;
				e.phase = BP_IDLE;
				done = 1'b1;
			end
			default: begin
				e.phase = BP_IDLE;
			end
			endcase
		end
		r.scl = e.scl;
		r.sda = e.sda;
		r.drv = e.drv;
		r.busy = (e.phase != BP_IDLE);
		r.done = done;
		r.rx = e.rx;
		r.err = err;
		return r;
	endfunction

	function automatic logic sda_draw(input int mode);
		case (mode)
		SDA_LOW: return 1'b0;
		SDA_HIGH: return 1'b1;
		SDA_COIN: return 1'($urandom_range(0, 1));
		default: return ($urandom_range(0, 7) != 0);
		endcase
	endfunction

	task automatic emit(input tick_t t);
		ticks_pending.push_back(t);
		void'(tick_engine(plan, bus_cfg, t));
	endtask

	// Offers one command tick (cmd_valid may be clear), then keeps the bus ticking until the planned engine is idle.
	task automatic issue(input logic cmdv, input logic [2:0] act, input logic [7:0] tx,
			input logic ack, input int mode);
		tick_t t;
		t.cmd = cmdv;
		t.act = act;
		t.tx = tx;
		t.ack = ack;
		t.sda = sda_draw(mode);
		emit(t);
		while (plan.phase != BP_IDLE) begin
			t.cmd = ($urandom_range(0, 7) == 0);
			t.act = 3'($urandom_range(0, 7));
			t.tx = 8'($urandom);
			t.ack = 1'($urandom_range(0, 1));
			t.sda = sda_draw(mode);
			emit(t);
		end
	endtask

	task automatic gen_mix(input int n);
		int base;
		int pick;
		base = ticks_pending.size();
		while (ticks_pending.size() - base < n) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				issue(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
					SDA_COIN);
			end else if (pick == 1) begin
				issue(1'b1, 3'($urandom_range(ACT_READ + 1, 7)), 8'($urandom),
					1'($urandom_range(0, 1)), SDA_COIN);
			end else begin
				issue(1'b1, 3'($urandom_range(ACT_START, ACT_READ)), 8'($urandom),
					1'($urandom_range(0, 1)), $urandom_range(SDA_LOW, SDA_MOSTLY_HIGH));
			end
		end
	endtask

	task automatic reg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_cfg(input logic [15:0] ld, input logic [15:0] sd, input logic [7:0] pl);
		reg_write(ADDR_LONG_DELAY, {16'd0, ld});
		reg_write(ADDR_SHORT_DELAY, {16'd0, sd});
		reg_write(ADDR_POLL_LIMIT, {24'd0, pl});
		bus_cfg.long_delay = ld;
		bus_cfg.short_delay = sd;
		bus_cfg.poll_limit = pl;
	endtask

	task automatic drain();
		@(posedge clk);
		while (ticks_pending.size() != 0 || s_tvalid || levels_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic flag(input string what, input logic [7:0] e, input logic [7:0] a);
		mism++;
		if (mism <= 10) begin
			$display("mismatch on %s at %0t ns: expected %0h, got %0h", what, $time, e, a);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (calm) begin
				send_gap = 0;
				ready_gap = 0;
			end
			if (!s_tvalid || in_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (ticks_pending.size() > 0) begin
					next_tick = ticks_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, next_tick.sda, next_tick.ack, next_tick.tx};
					s_tuser <= {next_tick.act, next_tick.cmd};
					if (!calm && $urandom_range(0, 15) == 0) begin
						send_gap = $urandom_range(1, 16);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (ready_gap > 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 15) == 0) begin
					ready_gap = $urandom_range(1, 16);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire = s_tvalid && s_tready;
			if (in_fire) begin
				fed.cmd = s_tuser[0];
				fed.act = s_tuser[3:1];
				fed.tx = s_tdata[7:0];
				fed.ack = s_tdata[8];
				fed.sda = s_tdata[9];
				levels_due.push_back(tick_engine(live, bus_cfg, fed));
			end
			if (m_tvalid && m_tready) begin
				seen.scl = m_tdata[0];
				seen.sda = m_tdata[1];
				seen.drv = m_tdata[2];
				seen.busy = m_tdata[3];
				seen.done = m_tdata[4];
				seen.rx = m_tdata[12:5];
				seen.err = m_tdata[13];
				if (levels_due.size() == 0) begin
					flag("unexpected output transfer", 8'd0, 8'd1);
				end else begin
					want = levels_due.pop_front();
					if (want.scl != seen.scl) flag("scl_level", 8'(want.scl), 8'(seen.scl));
					if (want.sda != seen.sda) flag("sda_level", 8'(want.sda), 8'(seen.sda));
					if (want.drv != seen.drv) flag("sda_drive", 8'(want.drv), 8'(seen.drv));
					if (want.busy != seen.busy) flag("busy_res", 8'(want.busy), 8'(seen.busy));
					if (want.done != seen.done) flag("done_res", 8'(want.done), 8'(seen.done));
					if (want.rx != seen.rx) flag("rx_byte", want.rx, seen.rx);
					if (want.err != seen.err) flag("ack_error", 8'(want.err), 8'(seen.err));
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("tb_i2c_master_bit_engine_top failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_fire = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		ready_gap = 0;
		mism = 0;
		plan = fresh_engine();
		live = fresh_engine();
		bus_cfg.long_delay = LONG_DELAY_RST;
		bus_cfg.short_delay = SHORT_DELAY_RST;
		bus_cfg.poll_limit = POLL_LIMIT_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		issue(1'b1, ACT_START, 8'h00, 1'b0, SDA_COIN);
		drain();

		set_cfg(16'd1, 16'd1, 8'd0);
		issue(1'b1, ACT_STOP, 8'h00, 1'b0, SDA_COIN);
		issue(1'b1, ACT_WRITE, 8'hFF, 1'b0, SDA_COIN);
		issue(1'b1, ACT_WRITE, 8'h00, 1'b1, SDA_COIN);
		issue(1'b1, ACT_WRITE, 8'hA5, 1'b0, SDA_MOSTLY_HIGH);
		issue(1'b1, ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
		issue(1'b1, ACT_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH);
		issue(1'b1, ACT_READ, 8'h00, 1'b1, SDA_HIGH);
		issue(1'b1, ACT_READ, 8'hFF, 1'b0, SDA_LOW);
		issue(1'b1, ACT_READ, 8'h3C, 1'b1, SDA_COIN);
		for (int a = ACT_READ + 1; a < 8; a++) begin
			issue(1'b1, 3'(a), 8'h5A, 1'b1, SDA_COIN);
		end
		issue(1'b0, ACT_WRITE, 8'hC3, 1'b0, SDA_COIN);
		drain();

		set_cfg(16'd0, 16'd0, 8'd3);
		gen_mix(60);
		drain();

		set_cfg(16'd1, 16'd1, 8'd255);
		issue(1'b1, ACT_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
		issue(1'b1, ACT_WAIT_ACK, 8'h00, 1'b0, SDA_MOSTLY_HIGH);
		drain();

		set_cfg(16'd24, 16'd1, 8'd2);
		issue(1'b1, ACT_START, 8'h00, 1'b0, SDA_COIN);
		drain();

		set_cfg(16'd1, 16'd24, 8'd2);
		issue(1'b1, ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
		drain();

		for (int k = 0; k < 6; k++) begin
			if (k == 5) begin
				calm = 1'b1;
			end
			set_cfg(($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 10))
					: 16'($urandom_range(1, 4)),
				16'($urandom_range(1, 3)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(7, 40))
					: 8'($urandom_range(0, 6)));
			gen_mix(25);
			drain();
		end

		repeat (20) @(posedge clk);
		if (mism == 0 && levels_due.size() == 0) begin
			$display("tb_i2c_master_bit_engine_top passed");
		end else begin
			$display("tb_i2c_master_bit_engine_top failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/i2cbe_pkg.sv
sv/i2cbe_front.sv
sv/i2cbe_fifo.sv
sv/i2cbe_engine.sv
sv/i2c_master_bit_engine_top.sv
sim/tb_i2c_master_bit_engine_top.sv
